>>> hdl/gebs_pkg.sv
// ----------------------------------------------------------------------------
// gebs_pkg
// shared constants and types for the bilinear elevation sampler
// ----------------------------------------------------------------------------
package gebs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // limits on the 9-bit width and height registers
  localparam int W_CAP = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
  localparam int H_CAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

  localparam int ADDR_W  = 16;
  localparam int ELEV_W  = 24;
  localparam int CELL_W  = ELEV_W + 1;
  localparam int DIM_W   = 9;
  localparam int POS_W   = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH      = 3'd0,
    REG_MAP_HEIGHT     = 3'd1,
    REG_ORIGIN_X       = 3'd2,
    REG_ORIGIN_Y       = 3'd3,
    REG_INV_RESOLUTION = 3'd4
  } cfg_reg_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

>>> hdl/gebs_ram.sv
// ----------------------------------------------------------------------------
// gebs_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module gebs_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 25
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/grid_elevation_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// grid_elevation_bilinear_sampler
// bilinear elevation lookup over a row-major grid held in one single-port ram
// ----------------------------------------------------------------------------
// A write request (in_func = 0) stores one cell; busy stays
// low and the next request may follow at once. A query request (in_func = 1)
// holds busy, and its result shows on out_valid for one cycle,
// in the cycle busy drops; a new request may be given in that same cycle.
// The busy time comes from the coordinate multiply and offset stages, four
// back-to-back reads of the neighbouring cells
// through the single ram port, and the multiply-accumulate tail that drains
// them. The result cannot be held off: capture it while out_valid is high.
// Registers are written through cfg_valid/cfg_ready; cfg_ready is high only
// while busy and start are both low.
// ----------------------------------------------------------------------------
module grid_elevation_bilinear_sampler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [gebs_pkg::ADDR_W-1:0]     in_cell_address,
  input  logic signed [gebs_pkg::ELEV_W-1:0] in_cell_elevation,
  input  logic                            in_cell_valid,
  input  logic signed [gebs_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [gebs_pkg::POS_W-1:0]  in_pos_y,
  output logic                            out_valid,
  output logic signed [gebs_pkg::ELEV_W-1:0] out_sampled_elevation,
  output logic                            out_sample_ok,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gebs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);

  import gebs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_PREP,
    S_READ,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]        map_width_r, map_height_r;
  logic signed [POS_W-1:0] origin_x_r, origin_y_r;
  logic [31:0]             inv_res_r;

  logic signed [32:0] dx_r, dy_r;
  logic signed [49:0] plx_r, phx_r, ply_r, phy_r;
  logic signed [49:0] sx_r, sy_r;

  logic [ADDR_W-1:0] addr_r [4];
  logic [32:0]       wt_r [4];
  logic [3:0]        used_r;
  logic              fail_r;
  logic [1:0]        cnt_r;
  logic [1:0]        rd_k_r;
  logic              rd_vld_r, prod_vld_r;
  logic signed [56:0] prod_r, acc_r;

  logic                         out_valid_r, out_ok_r;
  logic signed [ELEV_W-1:0]     out_elev_r;

  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic signed [33:0] x0, y0;
  logic signed [34:0] cx [2];
  logic signed [34:0] cy [2];
  logic [1:0]         inb_x, inb_y;
  logic [16:0]        wx [2];
  logic [16:0]        wy [2];
  logic [33:0]        wprod [4];
  logic [18:0]        idx [4];
  logic [3:0]         used;
  logic               bound_fail;
  logic signed [57:0] mulw;
  logic signed [56:0] rnd;
  logic               drain_done;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy && !start;

  assign ram_we    = accept && (in_func == FUNC_WRITE);
  assign ram_addr  = ram_we ? in_cell_address : addr_r[cnt_r];
  assign ram_wdata = {in_cell_valid, in_cell_elevation};

  gebs_ram #(
    .ADDR_BITS (ADDR_W),
    .DATA_BITS (CELL_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // neighbour setup from the registered cell coordinates
  always_comb begin
    w_eff = (map_width_r  > DIM_W'(W_CAP)) ? DIM_W'(W_CAP) : map_width_r;
    h_eff = (map_height_r > DIM_W'(H_CAP)) ? DIM_W'(H_CAP) : map_height_r;
    x0 = $signed(sx_r[49:16]);
    y0 = $signed(sy_r[49:16]);
    cx[0] = {x0[33], x0};
    cx[1] = {x0[33], x0} + 35'sd1;
    cy[0] = {y0[33], y0};
    cy[1] = {y0[33], y0} + 35'sd1;
    wx[0] = 17'h10000 - {1'b0, sx_r[15:0]};
    wx[1] = {1'b0, sx_r[15:0]};
    wy[0] = 17'h10000 - {1'b0, sy_r[15:0]};
    wy[1] = {1'b0, sy_r[15:0]};
    for (int j = 0; j < 2; j++) begin
      inb_x[j] = !cx[j][34] && (cx[j] < $signed({26'b0, w_eff}));
      inb_y[j] = !cy[j][34] && (cy[j] < $signed({26'b0, h_eff}));
    end
    bound_fail = 1'b0;
    for (int k = 0; k < 4; k++) begin
      wprod[k] = wx[k % 2] * wy[k / 2];
      used[k]  = ((k % 2 == 0) || (sx_r[15:0] != 16'd0)) &&
                 ((k / 2 == 0) || (sy_r[15:0] != 16'd0));
      idx[k]   = {10'b0, cy[k / 2][DIM_W-1:0]} * {10'b0, w_eff} +
                 {10'b0, cx[k % 2][DIM_W-1:0]};
      if (used[k] && !(inb_x[k % 2] && inb_y[k / 2])) begin
        bound_fail = 1'b1;
      end
    end
  end

  assign mulw       = $signed({1'b0, wt_r[rd_k_r]}) * $signed(ram_rdata[ELEV_W-1:0]);
  assign rnd        = acc_r + 57'sd2147483648;
  assign drain_done = !rd_vld_r && !prod_vld_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_func == FUNC_QUERY)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_PREP;
      S_PREP: state_nxt = S_READ;
      S_READ: begin
        if (cnt_r == 2'd3) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      inv_res_r    <= 32'h0001_0000;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      prod_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP_WIDTH:      map_width_r  <= cfg_data[DIM_W-1:0];
          REG_MAP_HEIGHT:     map_height_r <= cfg_data[DIM_W-1:0];
          REG_ORIGIN_X:       origin_x_r   <= $signed(cfg_data);
          REG_ORIGIN_Y:       origin_y_r   <= $signed(cfg_data);
          REG_INV_RESOLUTION: inv_res_r    <= cfg_data;
          default: ;
        endcase
      end

      out_valid_r <= 1'b0;
      rd_vld_r    <= (state_r == S_READ);
      rd_k_r      <= cnt_r;
      prod_vld_r  <= rd_vld_r;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            dx_r <= {in_pos_x[31], in_pos_x} - {origin_x_r[31], origin_x_r};
            dy_r <= {in_pos_y[31], in_pos_y} - {origin_y_r[31], origin_y_r};
          end
        end
        S_MUL: begin
          plx_r <= dx_r * $signed({1'b0, inv_res_r[15:0]});
          phx_r <= dx_r * $signed({1'b0, inv_res_r[31:16]});
          ply_r <= dy_r * $signed({1'b0, inv_res_r[15:0]});
          phy_r <= dy_r * $signed({1'b0, inv_res_r[31:16]});
        end
        S_SUM: begin
          // floor(d * inv / 2^16) less half a cell
          sx_r <= (plx_r >>> 16) + phx_r - 50'sd32768;
          sy_r <= (ply_r >>> 16) + phy_r - 50'sd32768;
        end
        S_PREP: begin
          for (int k = 0; k < 4; k++) begin
            addr_r[k] <= idx[k][ADDR_W-1:0];
            wt_r[k]   <= wprod[k][32:0];
          end
          used_r <= used;
          fail_r <= bound_fail;
          acc_r  <= '0;
          cnt_r  <= '0;
        end
        S_READ: begin
          cnt_r <= cnt_r + 2'd1;
        end
        S_DRAIN: begin
          if (drain_done) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= !fail_r;
            out_elev_r  <= fail_r ? '0 : $signed(rnd[55:32]);
          end
        end
        default: ;
      endcase

      if (rd_vld_r) begin
        prod_r <= mulw[56:0];
        if (used_r[rd_k_r] && !ram_rdata[ELEV_W]) begin
          fail_r <= 1'b1;
        end
      end
      if (prod_vld_r) begin
        acc_r <= acc_r + prod_r;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sample_ok         = out_ok_r;
  assign out_sampled_elevation = out_elev_r;

endmodule

>>> hdl/gebs_checker.sv
// ----------------------------------------------------------------------------
// gebs_checker
// port-level checks on request and result timing of the elevation sampler
// ----------------------------------------------------------------------------
module gebs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_sample_ok,
  input logic [23:0] out_sampled_elevation
);

  import gebs_pkg::*;

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_WRITE)) |=> !busy)
    else $error("write request left the block busy");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_QUERY)) |=> busy)
    else $error("query request did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sample_ok) |-> (out_sampled_elevation == 24'd0))
    else $error("failed sample carries nonzero elevation");

endmodule

bind grid_elevation_bilinear_sampler gebs_checker u_gebs_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .start                 (start),
  .busy                  (busy),
  .in_func               (in_func),
  .out_valid             (out_valid),
  .out_sample_ok         (out_sample_ok),
  .out_sampled_elevation (out_sampled_elevation)
);
